FILE: hw/rtl/asp_pkg.sv
package asp_pkg;

  // sizes
  localparam int MAX_PARTIALS = 16;
  localparam int TABLE_SIZE   = 512;
  localparam int FRAC_W       = 16;
  localparam int IP_W         = $clog2(TABLE_SIZE);
  localparam int PHASE_W      = IP_W + FRAC_W;
  localparam int IDX_W        = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
  localparam int QUARTER      = TABLE_SIZE / 4;
  localparam int Q_W          = $clog2(QUARTER) + 1;

  // field widths
  localparam int NPART_W = 5;
  localparam int GAIN_W  = 16;
  localparam int INC_W   = 25;
  localparam int OUT_W   = 24;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;
  localparam int SMP_W   = 17;

  // accumulator and scaling widths
  localparam int SUM_W   = 33 + $clog2(MAX_PARTIALS);
  localparam int LO_W    = 18;
  localparam int HI_W    = SUM_W - LO_W;
  localparam int MUL_A_W = (HI_W > LO_W + 1) ? HI_W : LO_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int TOT_W   = MUL_P_W + LO_W + 1;
  localparam int OUT_SH  = 22;

  localparam longint OUT_MAX = 64'sd8388607;
  localparam longint OUT_MIN = -64'sd8388608;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(32768);

  // opcodes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SET_INC  = 2'd1;
  localparam logic [1:0] OP_SET_GAIN = 2'd2;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_NUM_PARTIALS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_AMPLITUDE    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_STEREO_MODE  = 2'd2;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  typedef logic signed [15:0] quarter_tab_t [0:QUARTER];

  // restoring division by shift and subtract, used while building the table
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      rem = {rem[62:0], num[bit_i]};
      if (rem >= den) begin
        rem        = rem - den;
        quo[bit_i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave sine in Q1.15, integer Taylor series in Q30
  function automatic quarter_tab_t build_quarter();
    quarter_tab_t       t;
    longint unsigned    x;
    longint unsigned    term;
    longint             sum;
    longint             r;
    for (int q = 0; q <= QUARTER; q++) begin
      x    = (longint'(q) * TWO_PI_Q30) >> IP_W;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = div_u64(term, longint'((2 * k) * (2 * k + 1)));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 16384) >>> 15;
      if (r > 32767) begin
        r = 32767;
      end
      t[q] = 16'(r);
    end
    return t;
  endfunction

  localparam quarter_tab_t SINE_QUARTER = build_quarter();

  // full table entry 0..TABLE_SIZE by quarter-wave symmetry
  function automatic logic signed [15:0] sine_at(input logic [IP_W:0] i);
    logic [IP_W-1:0]    n;
    logic [IP_W-1:0]    q;
    logic               neg;
    logic signed [15:0] v;
    n   = i[IP_W-1:0];
    neg = 1'b0;
    if (int'(n) <= QUARTER) begin
      q = n;
    end else if (int'(n) <= 2 * QUARTER) begin
      q = IP_W'(2 * QUARTER) - n;
    end else if (int'(n) <= 3 * QUARTER) begin
      q   = n - IP_W'(2 * QUARTER);
      neg = 1'b1;
    end else begin
      q   = IP_W'(0) - n;
      neg = 1'b1;
    end
    v = SINE_QUARTER[Q_W'(q)];
    return neg ? -v : v;
  endfunction

endpackage

FILE: hw/rtl/additive_sine_partial_bank_pan_core.sv
// channel   ports                                      transfer when
// -------   ----------------------------------------   ----------------------
// input     start, busy, in_opcode .. in_right_gain    start high, busy low
// result    out_strobe, out_left_sample, out_right_..  out_strobe high
// config    cfg_we, cfg_index, cfg_wdata               cfg_we high
//
// set items finish at their transfer and leave busy low; a tick issues its active partials,
// one partial a cycle through the lookup / interpolate / weight pipeline,
// then two passes of the shared multipliers for amplitude scaling
// busy is high from the tick transfer until the result is registered
// the result shows for one cycle and cannot be stalled
// synchronous active-low reset clears state, sums, the strobe and all partials and loads default configuration
module additive_sine_partial_bank_pan_core import asp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_opcode,
  input  logic [3:0]               in_partial_index,
  input  logic [INC_W-1:0]         in_increment,
  input  logic [GAIN_W-1:0]        in_left_gain,
  input  logic [GAIN_W-1:0]        in_right_gain,
  output logic                     out_strobe,
  output logic signed [OUT_W-1:0]  out_left_sample,
  output logic signed [OUT_W-1:0]  out_right_sample,
  input  logic                     cfg_we,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_MLO   = 3'd3;
  localparam logic [2:0] ST_MHI   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  // configuration
  logic [NPART_W-1:0] num_r;
  logic [GAIN_W-1:0]  amp_r;
  logic               stereo_r;

  // per-partial state
  logic [PHASE_W-1:0] pa_r  [MAX_PARTIALS];
  logic [PHASE_W-1:0] inc_r [MAX_PARTIALS];
  logic [GAIN_W-1:0]  wl_r  [MAX_PARTIALS];
  logic [GAIN_W-1:0]  wr_r  [MAX_PARTIALS];

  // sequencer
  logic [2:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r;
  logic [NPART_W-1:0] n_eff;
  logic               last_issue;
  logic               accept, tick_go;
  logic [IDX_W-1:0]   set_idx;
  logic               set_ok;

  // pipeline
  logic [3:0]                pipe_v_r;
  logic [PHASE_W-1:0]        acc;
  logic [IP_W-1:0]           ip1_r;
  logic [FRAC_W-1:0]         fr1_r, fr2_r;
  logic [GAIN_W-1:0]         wl1_r, wr1_r, wl2_r, wr2_r, wl3_r, wr3_r;
  logic signed [15:0]        a2_r, b2_r;
  logic signed [16:0]        diff;
  logic signed [33:0]        interp_p;
  logic signed [34:0]        interp_s;
  logic signed [SMP_W-1:0]   y3_r;

  // shared multipliers and sums
  logic signed [MUL_A_W-1:0] mul_a_l, mul_a_r;
  logic signed [MUL_B_W-1:0] mul_b_l, mul_b_r;
  logic signed [MUL_P_W-1:0] prod_l_r, prod_r_r, plo_l_r, plo_r_r;
  logic signed [SUM_W-1:0]   sum_l_r, sum_r_r;
  logic signed [TOT_W-1:0]   tot_l, tot_r, sh_l, sh_r;
  logic signed [OUT_W-1:0]   sat_l, sat_r;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign tick_go = accept && (in_opcode == OP_TICK);
  assign set_idx = IDX_W'(in_partial_index);
  assign set_ok  = (int'(in_partial_index) < MAX_PARTIALS);

  // active partial count, clamped to the bank size
  assign n_eff      = (int'(num_r) > MAX_PARTIALS) ? NPART_W'(MAX_PARTIALS) : num_r;
  assign last_issue = (int'(cnt_r) + 1 >= int'(n_eff));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r    <= NPART_W'(10);
      amp_r    <= GAIN_W'(32768);
      stereo_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_PARTIALS: num_r    <= cfg_wdata[NPART_W-1:0];
        REG_AMPLITUDE:    amp_r    <= cfg_wdata[GAIN_W-1:0];
        REG_STEREO_MODE:  stereo_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // phase advance of the partial being issued
  assign acc = pa_r[cnt_r] + inc_r[cnt_r];

  // partial state: set items and phase write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PARTIALS; i++) begin
        pa_r[i]  <= '0;
        inc_r[i] <= '0;
        wl_r[i]  <= '0;
        wr_r[i]  <= '0;
      end
    end else begin
      if (accept && set_ok && in_opcode == OP_SET_INC) begin
        inc_r[set_idx] <= PHASE_W'(in_increment);
      end
      if (accept && set_ok && in_opcode == OP_SET_GAIN) begin
        wl_r[set_idx] <= in_left_gain;
        wr_r[set_idx] <= in_right_gain;
      end
      if (state_r == ST_RUN) begin
        pa_r[cnt_r] <= acc;
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (tick_go) begin
          state_nxt = (n_eff == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_v_r == '0) begin
          state_nxt = ST_MLO;
        end
      end
      ST_MLO:  state_nxt = ST_MHI;
      ST_MHI:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      pipe_v_r <= '0;
    end else begin
      state_r  <= state_nxt;
      pipe_v_r <= {pipe_v_r[2:0], state_r == ST_RUN};
      if (tick_go) begin
        cnt_r <= '0;
      end else if (state_r == ST_RUN) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
    end
  end

  // stage 1: phase split and weight pick
  always_ff @(posedge clk) begin
    ip1_r <= acc[PHASE_W-1:FRAC_W];
    fr1_r <= acc[FRAC_W-1:0];
    wl1_r <= stereo_r ? wl_r[cnt_r] : UNITY_GAIN;
    wr1_r <= stereo_r ? wr_r[cnt_r] : UNITY_GAIN;
  end

  // stage 2: table lookups of both neighbors
  always_ff @(posedge clk) begin
    a2_r  <= sine_at({1'b0, ip1_r});
    b2_r  <= sine_at({1'b0, ip1_r} + (IP_W + 1)'(1));
    fr2_r <= fr1_r;
    wl2_r <= wl1_r;
    wr2_r <= wr1_r;
  end

  // stage 3: linear interpolation with rounding
  assign diff     = 17'(b2_r) - 17'(a2_r);
  assign interp_p = 34'(diff) * $signed({18'd0, fr2_r});
  assign interp_s = ($signed(35'(a2_r)) <<< FRAC_W) + 35'(interp_p)
                  + $signed(35'(32768));

  always_ff @(posedge clk) begin
    y3_r  <= interp_s[FRAC_W + SMP_W - 1:FRAC_W];
    wl3_r <= wl2_r;
    wr3_r <= wr2_r;
  end

  // shared multiplier operands: weighting, then amplitude low and high halves
  always_comb begin
    case (state_r)
      ST_MLO: begin
        mul_a_l = $signed(MUL_A_W'({1'b0, sum_l_r[LO_W-1:0]}));
        mul_a_r = $signed(MUL_A_W'({1'b0, sum_r_r[LO_W-1:0]}));
        mul_b_l = $signed({1'b0, amp_r});
        mul_b_r = $signed({1'b0, amp_r});
      end
      ST_MHI: begin
        mul_a_l = MUL_A_W'(sum_l_r[SUM_W-1:LO_W]);
        mul_a_r = MUL_A_W'(sum_r_r[SUM_W-1:LO_W]);
        mul_b_l = $signed({1'b0, amp_r});
        mul_b_r = $signed({1'b0, amp_r});
      end
      default: begin
        mul_a_l = MUL_A_W'(y3_r);
        mul_a_r = MUL_A_W'(y3_r);
        mul_b_l = $signed({1'b0, wl3_r});
        mul_b_r = $signed({1'b0, wr3_r});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_l_r <= MUL_P_W'(mul_a_l) * MUL_P_W'(mul_b_l);
    prod_r_r <= MUL_P_W'(mul_a_r) * MUL_P_W'(mul_b_r);
    if (state_r == ST_MHI) begin
      plo_l_r <= prod_l_r;
      plo_r_r <= prod_r_r;
    end
  end

  // accumulation of weighted partials
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_l_r <= '0;
      sum_r_r <= '0;
    end else if (tick_go) begin
      sum_l_r <= '0;
      sum_r_r <= '0;
    end else if (pipe_v_r[3]) begin
      sum_l_r <= sum_l_r + SUM_W'(prod_l_r);
      sum_r_r <= sum_r_r + SUM_W'(prod_r_r);
    end
  end

  // recombine halves, round, shift and saturate
  assign tot_l = (TOT_W'(prod_l_r) <<< LO_W) + TOT_W'(plo_l_r)
               + (TOT_W'(1) <<< (OUT_SH - 1));
  assign tot_r = (TOT_W'(prod_r_r) <<< LO_W) + TOT_W'(plo_r_r)
               + (TOT_W'(1) <<< (OUT_SH - 1));
  assign sh_l  = tot_l >>> OUT_SH;
  assign sh_r  = tot_r >>> OUT_SH;

  always_comb begin
    if (sh_l > OUT_MAX) begin
      sat_l = OUT_W'(OUT_MAX);
    end else if (sh_l < OUT_MIN) begin
      sat_l = OUT_W'(OUT_MIN);
    end else begin
      sat_l = sh_l[OUT_W-1:0];
    end
    if (sh_r > OUT_MAX) begin
      sat_r = OUT_W'(OUT_MAX);
    end else if (sh_r < OUT_MIN) begin
      sat_r = OUT_W'(OUT_MIN);
    end else begin
      sat_r = sh_r[OUT_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (state_r == ST_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      out_left_sample  <= sat_l;
      out_right_sample <= sat_r;
    end
  end

`ifndef SYNTHESIS
  // a result follows only the final scaling step
  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_FIN))
    else $error("result strobe without final scaling step");

  // a tick transfer makes the block busy
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go |=> busy)
    else $error("tick transfer did not start the sequencer");

  // pipeline holds work only while partials are issued or drained
  a_pipe_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_v_r != '0) |-> (state_r == ST_RUN || state_r == ST_DRAIN))
    else $error("partial pipeline active outside a tick");

  // issued partial index stays below the active count
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (int'(cnt_r) < int'(n_eff)))
    else $error("partial counter beyond active partials");
`endif

endmodule
